// File: rtl/core/integer_to_radix_digits_macros.svh
// Assertion helpers for the checker file i2r_checker.sv.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define I2R_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define I2R_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/i2r_pkg.sv
package i2r_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int BASE_W      = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;

	localparam int S_TDATA_W   = ((VALUE_WIDTH + BASE_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = 8;

	// quotient bits resolved per division cycle
	localparam int BITS_PER_STEP = 8;
	localparam int DIV_CYCLES    = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int DW            = DIV_CYCLES * BITS_PER_STEP;
	localparam int STEP_W        = $clog2(DIV_CYCLES + 1);

	localparam int DIGIT_DEPTH = VALUE_WIDTH;
	localparam int IDX_W       = $clog2(DIGIT_DEPTH);

	localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_A        = 7'd65;
	localparam logic [CHAR_W-1:0] CHAR_NINE     = 7'd57;
	localparam logic [CHAR_W-1:0] CHAR_Z        = 7'd90;
	localparam logic [BASE_W-1:0] BASE_MIN      = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX      = 6'd36;
	localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [BASE_W-1:0]      base;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_LIMIT) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DECIMAL_LIMIT);
		end
		return c;
	endfunction

endpackage

// File: rtl/core/i2r_front.sv
module i2r_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [i2r_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          push_valid,
	input  logic                          push_ready,
	output i2r_pkg::item_t                push_item
);
	import i2r_pkg::*;

	logic [VALUE_WIDTH-1:0] value;
	logic [BASE_W-1:0]      radix;

	assign value = s_tdata[VALUE_WIDTH-1:0];
	assign radix = s_tdata[VALUE_WIDTH +: BASE_W];

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		// zero or negative collapses to zero: a single '0' digit
		if (value[VALUE_WIDTH-1] || (value == '0)) begin
			push_item.value = '0;
		end else begin
			push_item.value = value;
		end
		if (radix < BASE_MIN) begin
			push_item.base = BASE_MIN;
		end else if (radix > BASE_MAX) begin
			push_item.base = BASE_MAX;
		end else begin
			push_item.base = radix;
		end
	end

endmodule

// File: rtl/core/i2r_queue.sv
module i2r_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  i2r_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output i2r_pkg::item_t pop_item
);
	import i2r_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: rtl/core/i2r_back.sv
module i2r_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  i2r_pkg::item_t                pop_item,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [i2r_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import i2r_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [STEP_W-1:0]  step_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [DW-1:0]      dividend_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [BASE_W-1:0]  base_q;
	logic [DIGIT_W-1:0] rdata_q;
	logic [DIGIT_W-1:0] digit_mem [DIGIT_DEPTH];

	logic [DW-1:0]      div_next;
	logic [DIGIT_W-1:0] rem_next;
	logic               last_step;
	logic               quot_zero;
	logic               mem_we;
	logic               load;

	// one slice of restoring division by the base
	always_comb begin
		logic [DIGIT_W-1:0]       r;
		logic [DIGIT_W:0]         t;
		logic [BITS_PER_STEP-1:0] qb;
		r  = rem_q;
		qb = '0;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t = {r, dividend_q[DW-1-i]};
			if (t >= {1'b0, base_q}) begin
				r  = DIGIT_W'(t - {1'b0, base_q});
				qb[BITS_PER_STEP-1-i] = 1'b1;
			end else begin
				r = t[DIGIT_W-1:0];
			end
		end
		rem_next = r;
		div_next = (dividend_q << BITS_PER_STEP) | DW'(qb);
	end

	assign last_step = (step_q == STEP_W'(DIV_CYCLES - 1));
	assign quot_zero = (div_next == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (pop_valid) state_d = ST_DIV;
			ST_DIV:      if (last_step && quot_zero) state_d = ST_EMIT_RD;
			ST_EMIT_RD:  state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (m_tready) state_d = (rd_idx_q == '0) ? ST_IDLE : ST_EMIT_RD;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		mem_we    = 1'b0;
		m_tvalid  = 1'b0;
		case (state_q)
			ST_IDLE:     pop_ready = 1'b1;
			ST_DIV:      mem_we    = last_step;
			ST_EMIT_OUT: m_tvalid  = 1'b1;
			default: begin
			end
		endcase
	end

	assign load    = pop_ready && pop_valid;
	assign m_tdata = M_TDATA_W'(digit_to_ascii(rdata_q));
	assign m_tlast = (rd_idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
				cnt_q  <= '0;
			end else if (state_q == ST_DIV) begin
				if (last_step) begin
					step_q <= '0;
					if (quot_zero) begin
						rd_idx_q <= cnt_q;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end else if ((state_q == ST_EMIT_OUT) && m_tready && (rd_idx_q != '0)) begin
				rd_idx_q <= rd_idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dividend_q <= DW'(pop_item.value);
			base_q     <= pop_item.base;
			rem_q      <= '0;
		end else if (state_q == ST_DIV) begin
			dividend_q <= div_next;
			// restart the remainder for the next digit
			rem_q      <= last_step ? '0 : rem_next;
		end
	end

	// digit stack, least significant digit at index zero
	always_ff @(posedge clk) begin
		if (mem_we) digit_mem[cnt_q] <= rem_next;
	end

	always_ff @(posedge clk) begin
		rdata_q <= digit_mem[rd_idx_q];
	end

endmodule

// File: rtl/core/integer_to_radix_digits.sv
// Sequence: a request is taken from the queue in ST_IDLE, then each digit is divided out in
// ST_DIV one slice at a time; each digit shown on the output passes a memory read, then a hold.
// Requests: a new request is taken only after the last digit of the previous one is accepted;
// the queue holds up to two waiting. The shared divider resolves 8 quotient bits a cycle.
// Reset: asynchronous, active low; clears the queue and the sequencer, the digit
// memory is not cleared and needs no clearing pass.
module integer_to_radix_digits (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [i2r_pkg::S_TDATA_W-1:0] s_tdata,  // value, radix, zero fill
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [i2r_pkg::M_TDATA_W-1:0] m_tdata,  // digit_char, zero fill
	output logic                          m_tlast   // last
);
	import i2r_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	i2r_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	i2r_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	i2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// File: rtl/core/i2r_checker.sv
`include "integer_to_radix_digits_macros.svh"

module i2r_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [i2r_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [i2r_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);
	import i2r_pkg::*;

	logic char_ok;
	logic s_seen;

	assign s_seen  = s_tvalid && s_tready && (s_tdata != '0 || 1'b1);
	assign char_ok = ((m_tdata >= M_TDATA_W'(CHAR_ZERO)) && (m_tdata <= M_TDATA_W'(CHAR_NINE)))
		|| ((m_tdata >= M_TDATA_W'(CHAR_A)) && (m_tdata <= M_TDATA_W'(CHAR_Z)));

	// a stalled digit holds
	`I2R_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

	`I2R_ASSERT_NOW(a_out_char, m_tvalid, char_ok, "output is not a digit character")

	// each digit is fetched from the stack before it is shown
	`I2R_ASSERT_NXT(a_out_gap, m_tvalid && m_tready, !m_tvalid, "digits shown back to back")

	`I2R_ASSERT_NXT(a_in_gap, s_seen && m_tvalid && m_tready && !m_tlast, !m_tvalid,
		"digit shown without fetch while taking a request")

endmodule

bind integer_to_radix_digits i2r_checker u_i2r_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
